[rtl/pfp_pkg.sv]
// Shared types and constants of the poison flag propagation unit.
// Depends on nothing; pfp_check, pfp_mul, the top level and the testbench import it.
package pfp_pkg;

    localparam int MAX_WIDTH_DEF = 64;

    // Positions of the wrap and exactness flags in an item.
    localparam int FLAG_NSW   = 0;
    localparam int FLAG_NUW   = 1;
    localparam int FLAG_EXACT = 2;

    // Operation codes; code fifteen is not named and behaves as pass.
    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_SUB       = 4'd1,
        CMD_MUL       = 4'd2,
        CMD_DIV_EXACT = 4'd3,
        CMD_DIV       = 4'd4,
        CMD_REM       = 4'd5,
        CMD_AND       = 4'd6,
        CMD_OR        = 4'd7,
        CMD_XOR       = 4'd8,
        CMD_SHL       = 4'd9,
        CMD_LSHR      = 4'd10,
        CMD_ASHR      = 4'd11,
        CMD_SELECT    = 4'd12,
        CMD_CONVERT   = 4'd13,
        CMD_PASS      = 4'd14
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ANTIDOTE_AND_OR = 2'd0,
        CFG_POISON_EQ_UNDEF = 2'd1,
        CFG_ANTIDOTE_SELECT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic antidote_and_or;
        logic poison_eq_undef;
        logic antidote_select;
    } cfg_t;

    // Outcome of the combinational checks: the poison so far, and whether the
    // signed multiply overflow or the exact division check still applies.
    typedef struct packed {
        logic simple_p;
        logic mul_chk;
        logic div_chk;
    } chk_t;

endpackage

[rtl/pfp_if.sv]
// Handshake channels of the poison flag propagation unit: item input,
// result output and configuration writes. No dependencies.
interface pfp_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [6:0]  width;
    logic [63:0] lhs_value;
    logic        lhs_poison;
    logic [63:0] rhs_value;
    logic        rhs_poison;
    logic        third_poison;
    logic [63:0] result_value;
    logic        result_poison_in;
    logic [5:0]  shift_amount;
    logic [2:0]  flags;

    modport source (
        output valid, cmd, width, lhs_value, lhs_poison, rhs_value, rhs_poison,
               third_poison, result_value, result_poison_in, shift_amount, flags,
        input  ready
    );
    modport sink (
        input  valid, cmd, width, lhs_value, lhs_poison, rhs_value, rhs_poison,
               third_poison, result_value, result_poison_in, shift_amount, flags,
        output ready
    );
endinterface

interface pfp_result_if;
    logic valid;
    logic ready;
    logic poison_out;

    modport source (output valid, poison_out, input ready);
    modport sink (input valid, poison_out, output ready);
endinterface

interface pfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/pfp_check.sv]
// Combinational poison checks and signed multiply operand preparation.
// Depends on pfp_pkg.
module pfp_check
    import pfp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  cmd_t                         cmd,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] w,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] s,
    input  logic [MAX_WIDTH-1:0]         lv,
    input  logic [MAX_WIDTH-1:0]         rv,
    input  logic [MAX_WIDTH-1:0]         res,
    input  logic [MAX_WIDTH-1:0]         m,
    input  logic                         lp,
    input  logic                         rp,
    input  logic                         tp,
    input  logic                         pin,
    input  logic [2:0]                   flags,
    input  cfg_t                         cfg,
    output chk_t                         chk,
    output logic [MAX_WIDTH-1:0]         ma,
    output logic [MAX_WIDTH-1:0]         mb,
    output logic [MAX_WIDTH-1:0]         limit
);

    localparam int DW = MAX_WIDTH;
    localparam int WW = $clog2(DW + 1);
    localparam int IW = $clog2(DW);

    function automatic logic [DW-1:0] low_mask(input logic [WW-1:0] n);
        if (n >= WW'(DW))
            return '1;
        else
            return (DW'(1) << n) - DW'(1);
    endfunction

    function automatic logic [WW-1:0] bit_len(input logic [DW-1:0] x);
        logic [WW-1:0] n;
        n = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (x[i])
                n = WW'(i + 1);
        end
        return n;
    endfunction

    logic [IW-1:0] wm1;
    logic          l_neg, r_neg, res_neg, r_pos;
    logic [DW-1:0] lsx, rsx, ressx;
    logic          slt_l_res, slt_res_l;
    logic [WW:0]   bl_sum;
    logic [DW-1:0] hi_mask, top, lo_mask, hide;
    logic          nsw, nuw, exact, anti_logic;
    logic          p, mc, dc;

    assign wm1     = IW'(w - WW'(1));
    assign l_neg   = lv[wm1];
    assign r_neg   = rv[wm1];
    assign res_neg = res[wm1];
    assign r_pos   = !r_neg && (rv != '0);

    // Sign-extend the active width to the full datapath.
    assign lsx   = l_neg ? (lv | ~m) : lv;
    assign rsx   = r_neg ? (rv | ~m) : rv;
    assign ressx = res_neg ? (res | ~m) : res;

    assign slt_l_res = $signed(lsx) < $signed(ressx);
    assign slt_res_l = $signed(ressx) < $signed(lsx);

    assign bl_sum  = {1'b0, bit_len(lv)} + {1'b0, bit_len(rv)};
    assign hi_mask = m & ~low_mask(w - s);
    assign top     = lv & hi_mask;
    assign lo_mask = low_mask(s);
    assign hide    = (cmd == CMD_AND) ? '0 : m;

    assign nsw   = flags[FLAG_NSW];
    assign nuw   = flags[FLAG_NUW];
    assign exact = flags[FLAG_EXACT];
    assign anti_logic = cfg.antidote_and_or | cfg.poison_eq_undef;

    // Magnitudes and the signed range bound for the multiply overflow check.
    assign ma    = l_neg ? (~lsx + DW'(1)) : lv;
    assign mb    = r_neg ? (~rsx + DW'(1)) : rv;
    assign limit = (DW'(1) << wm1) - ((l_neg ^ r_neg) ? DW'(0) : DW'(1));

    always_comb
    begin
        p  = pin;
        mc = 1'b0;
        dc = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                if (nsw && (r_neg ? slt_l_res : slt_res_l))
                    p = 1'b1;
                if (nuw && ((res < lv) || (res < rv)))
                    p = 1'b1;
            end
            CMD_SUB:
            begin
                if (nsw && (r_pos ? slt_l_res : slt_res_l))
                    p = 1'b1;
                if (nuw && (lv < rv))
                    p = 1'b1;
            end
            CMD_MUL:
            begin
                if (cfg.antidote_and_or && ((lp && rv == '0) || (lv == '0 && rp)))
                    p = 1'b0;
                else if (lp || rp)
                    p = 1'b1;
                else
                begin
                    if (nuw && (bl_sum > {1'b0, w}))
                        p = 1'b1;
                    mc = nsw;
                end
            end
            CMD_DIV_EXACT:
            begin
                dc = exact;
            end
            CMD_DIV, CMD_REM, CMD_XOR:
            begin
                p = lp | rp;
            end
            CMD_AND, CMD_OR:
            begin
                p = lp | rp;
                if (anti_logic && ((lp && !rp && rv == hide) || (!lp && rp && lv == hide)))
                    p = 1'b0;
            end
            CMD_SHL:
            begin
                if (s != '0)
                begin
                    if (nsw && (res_neg ? (top != hi_mask) : (top != '0)))
                        p = 1'b1;
                    if (nuw && (top != '0))
                        p = 1'b1;
                end
            end
            CMD_LSHR, CMD_ASHR:
            begin
                if (exact && (s != '0) && ((lv & lo_mask) != '0))
                    p = 1'b1;
            end
            CMD_SELECT:
            begin
                if (cfg.antidote_select)
                    p = lp | rp | tp;
                else
                    p = lp | ((lv == '0) ? tp : rp);
            end
            CMD_CONVERT:
            begin
                p = lp;
            end
            default:
            begin
                p = pin;
            end
        endcase
    end

    assign chk.simple_p = p;
    assign chk.mul_chk  = mc;
    assign chk.div_chk  = dc;

endmodule

[rtl/pfp_mul.sv]
// Two-stage split multiplier for the signed overflow and exact division
// checks. Depends on pfp_pkg.
module pfp_mul
    import pfp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 en_a,
    input  logic                 en_b,
    input  logic [MAX_WIDTH-1:0] ma,
    input  logic [MAX_WIDTH-1:0] mb,
    input  logic [MAX_WIDTH-1:0] limit,
    input  logic [MAX_WIDTH-1:0] drv,
    input  logic [MAX_WIDTH-1:0] dres,
    input  logic [MAX_WIDTH-1:0] dlv,
    input  logic [MAX_WIDTH-1:0] dm,
    output logic                 ovf,
    output logic                 div_bad
);

    localparam int DW = MAX_WIDTH;
    localparam int PW = 2 * ((DW + 1) / 2);
    localparam int H  = PW / 2;

    logic [PW-1:0] a, b, c, d;
    logic [PW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, q00_reg;
    logic [H-1:0]  q01_reg, q10_reg;
    logic [DW-1:0] limit_a_reg, lv_a_reg, m_a_reg;
    logic [PW+1:0] mid_reg;
    logic [H-1:0]  lo_reg;
    logic          p11nz_reg;
    logic [PW-1:0] dlow_reg;
    logic [DW-1:0] limit_b_reg, lv_b_reg, m_b_reg;
    logic [H-1:0]  q_sum;
    logic [PW-1:0] lower;

    assign a = PW'(ma);
    assign b = PW'(mb);
    assign c = PW'(drv);
    assign d = PW'(dres);

    // Partial products of half-width slices.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            p00_reg     <= PW'(a[H-1:0]) * PW'(b[H-1:0]);
            p01_reg     <= PW'(a[H-1:0]) * PW'(b[PW-1:H]);
            p10_reg     <= PW'(a[PW-1:H]) * PW'(b[H-1:0]);
            p11_reg     <= PW'(a[PW-1:H]) * PW'(b[PW-1:H]);
            q00_reg     <= PW'(c[H-1:0]) * PW'(d[H-1:0]);
            q01_reg     <= H'(c[H-1:0] * d[PW-1:H]);
            q10_reg     <= H'(c[PW-1:H] * d[H-1:0]);
            limit_a_reg <= limit;
            lv_a_reg    <= dlv;
            m_a_reg     <= dm;
        end
    end

    assign q_sum = q01_reg + q10_reg;

    // Column sums of the partial products.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            mid_reg     <= (PW+2)'(p00_reg[PW-1:H]) + (PW+2)'(p01_reg) + (PW+2)'(p10_reg);
            lo_reg      <= p00_reg[H-1:0];
            p11nz_reg   <= (p11_reg != '0);
            dlow_reg    <= q00_reg + {q_sum, {H{1'b0}}};
            limit_b_reg <= limit_a_reg;
            lv_b_reg    <= lv_a_reg;
            m_b_reg     <= m_a_reg;
        end
    end

    assign lower   = {mid_reg[H-1:0], lo_reg};
    assign ovf     = p11nz_reg || (mid_reg[PW+1:H] != '0) || (lower > PW'(limit_b_reg));
    assign div_bad = (dlow_reg[DW-1:0] & m_b_reg) != lv_b_reg;

endmodule

[rtl/poison_flag_propagation_unit.sv]
// Poison flag propagation unit, top level: input normalization, pipeline
// control and configuration. Depends on pfp_pkg, pfp_if, pfp_check, pfp_mul.
// Throughput: one word per cycle unless the output stalls; the depth is set by the split multiplier.
// Reset clears the configuration registers and all pipeline valid bits.
module poison_flag_propagation_unit
    import pfp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    pfp_item_if.sink      item,
    pfp_result_if.source  result,
    pfp_cfg_if.sink       cfg
);

    localparam int DW = MAX_WIDTH;
    localparam int WW = $clog2(DW + 1);

    // The pipeline has five register stages:
    //   s1  normalized word (width clamped, values masked, shift clamped)
    //   s2  outcome of the pfp_check checks plus multiply operands
    //   s3  partial products (inside pfp_mul)
    //   s4  column sums (inside pfp_mul)
    //   out final poison bit, held until the consumer takes it
    // Each stage loads when it is empty or the stage after it moves, so
    // bubbles collapse and a stall at the output loses no word.

    cfg_t cfg_reg, cfg_next;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic e1, e2, e3, e4, eo;

    logic [WW-1:0] w_norm, s_norm;
    logic [DW-1:0] m_norm;

    cmd_t          s1_cmd_reg;
    logic [WW-1:0] s1_w_reg, s1_s_reg;
    logic [DW-1:0] s1_lv_reg, s1_rv_reg, s1_res_reg, s1_m_reg;
    logic          s1_lp_reg, s1_rp_reg, s1_tp_reg, s1_pin_reg;
    logic [2:0]    s1_flags_reg;

    chk_t          chk_next;
    logic [DW-1:0] ma_next, mb_next, limit_next;

    chk_t          s2_chk_reg, s3_chk_reg, s4_chk_reg;
    logic [DW-1:0] s2_ma_reg, s2_mb_reg, s2_limit_reg;
    logic [DW-1:0] s2_rv_reg, s2_res_reg, s2_lv_reg, s2_m_reg;

    logic ovf, div_bad;
    logic poison_reg, poison_next;

    // Configuration: always ready, writes beyond the register list are ignored.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_ANTIDOTE_AND_OR: cfg_next.antidote_and_or = cfg.data;
                CFG_POISON_EQ_UNDEF: cfg_next.poison_eq_undef = cfg.data;
                CFG_ANTIDOTE_SELECT: cfg_next.antidote_select = cfg.data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Stage enables, from the output backwards.
    assign eo = !out_v_reg || result.ready;
    assign e4 = !s4_v_reg || eo;
    assign e3 = !s3_v_reg || e4;
    assign e2 = !s2_v_reg || e3;
    assign e1 = !s1_v_reg || e2;

    assign item.ready = e1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (e1)
                s1_v_reg <= item.valid;
            if (e2)
                s2_v_reg <= s1_v_reg;
            if (e3)
                s3_v_reg <= s2_v_reg;
            if (e4)
                s4_v_reg <= s3_v_reg;
            if (eo)
                out_v_reg <= s4_v_reg;
        end
    end

    // Width zero counts as one, widths above the datapath saturate, and a
    // shift longer than the width is clamped to it.
    always_comb
    begin
        if (item.width == 7'd0)
            w_norm = WW'(1);
        else if (item.width > 7'(DW))
            w_norm = WW'(DW);
        else
            w_norm = WW'(item.width);

        if ({1'b0, item.shift_amount} > 7'(w_norm))
            s_norm = w_norm;
        else
            s_norm = WW'(item.shift_amount);

        if (w_norm >= WW'(DW))
            m_norm = '1;
        else
            m_norm = (DW'(1) << w_norm) - DW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (e1)
        begin
            s1_cmd_reg   <= cmd_t'(item.cmd);
            s1_w_reg     <= w_norm;
            s1_s_reg     <= s_norm;
            s1_lv_reg    <= item.lhs_value[DW-1:0] & m_norm;
            s1_rv_reg    <= item.rhs_value[DW-1:0] & m_norm;
            s1_res_reg   <= item.result_value[DW-1:0] & m_norm;
            s1_m_reg     <= m_norm;
            s1_lp_reg    <= item.lhs_poison;
            s1_rp_reg    <= item.rhs_poison;
            s1_tp_reg    <= item.third_poison;
            s1_pin_reg   <= item.result_poison_in;
            s1_flags_reg <= item.flags;
        end
    end

    pfp_check #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_check (
        .cmd   (s1_cmd_reg),
        .w     (s1_w_reg),
        .s     (s1_s_reg),
        .lv    (s1_lv_reg),
        .rv    (s1_rv_reg),
        .res   (s1_res_reg),
        .m     (s1_m_reg),
        .lp    (s1_lp_reg),
        .rp    (s1_rp_reg),
        .tp    (s1_tp_reg),
        .pin   (s1_pin_reg),
        .flags (s1_flags_reg),
        .cfg   (cfg_reg),
        .chk   (chk_next),
        .ma    (ma_next),
        .mb    (mb_next),
        .limit (limit_next)
    );

    always_ff @(posedge clk)
    begin
        if (e2)
        begin
            s2_chk_reg   <= chk_next;
            s2_ma_reg    <= ma_next;
            s2_mb_reg    <= mb_next;
            s2_limit_reg <= limit_next;
            s2_rv_reg    <= s1_rv_reg;
            s2_res_reg   <= s1_res_reg;
            s2_lv_reg    <= s1_lv_reg;
            s2_m_reg     <= s1_m_reg;
        end
        if (e3)
            s3_chk_reg <= s2_chk_reg;
        if (e4)
            s4_chk_reg <= s3_chk_reg;
        if (eo)
            poison_reg <= poison_next;
    end

    // The multiplier stages move with the s3 and s4 enables.
    pfp_mul #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_mul (
        .clk     (clk),
        .en_a    (e3),
        .en_b    (e4),
        .ma      (s2_ma_reg),
        .mb      (s2_mb_reg),
        .limit   (s2_limit_reg),
        .drv     (s2_rv_reg),
        .dres    (s2_res_reg),
        .dlv     (s2_lv_reg),
        .dm      (s2_m_reg),
        .ovf     (ovf),
        .div_bad (div_bad)
    );

    assign poison_next = s4_chk_reg.simple_p
                       | (s4_chk_reg.mul_chk & ovf)
                       | (s4_chk_reg.div_chk & div_bad);

    assign result.valid      = out_v_reg;
    assign result.poison_out = poison_reg;

    // An empty output register must never hold off the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> item.ready)
        else $error("input not ready while output register is empty");

    // A word in the last stage that cannot move stays there and the
    // output keeps its word.
    a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_v_reg && !eo) |=> (s4_v_reg && out_v_reg))
        else $error("word lost while the output is stalled");

    // Every accepted word enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> s1_v_reg)
        else $error("accepted word did not enter the pipeline");

endmodule

[verif/poison_flag_propagation_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for poison_flag_propagation_unit.
// Depends on rtl/pfp_pkg.sv, rtl/pfp_if.sv and the RTL of the block itself.
module poison_flag_propagation_unit_test;
    import pfp_pkg::*;

    // Opcode fifteen has no name in the package; the block treats it as pass.
    localparam logic [3:0] CMD_RESERVED = 4'd15;
    // Register index past the end of the register list; writes to it are ignored.
    localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
    // Quiet cycles allowed after the last result before touching the configuration.
    localparam int SETTLE_CYCLES = 12;
    localparam int WORDS_PER_PHASE = 200;
    localparam int RANDOM_PHASES = 8;

    // One operation word as the sender sees it.
    typedef struct {
        logic [3:0]  cmd;
        logic [6:0]  width;
        logic [63:0] lhs_value;
        logic        lhs_poison;
        logic [63:0] rhs_value;
        logic        rhs_poison;
        logic        third_poison;
        logic [63:0] result_value;
        logic        result_poison_in;
        logic [5:0]  shift_amount;
        logic [2:0]  flags;
    } word_t;

    logic clk;
    logic rst_n;

    pfp_item_if   item_bus ();
    pfp_result_if result_bus ();
    pfp_cfg_if    cfg_bus ();

    poison_flag_propagation_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Words waiting to be sent, and the poison bits the block owes us in order.
    word_t pending_words[$];
    logic  poison_expected[$];

    // Our own copy of the configuration registers, updated when a write is taken.
    cfg_t  active_cfg;
    word_t accepted_word;
    logic  word_taken;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs; far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] width_mask(input int unsigned n);
        if (n >= 64)
        begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] x, input int unsigned ew);
        logic [63:0] m;
        m = width_mask(ew);
        x = x & m;
        if (ew < 64 && x[ew - 1])
        begin
            x = x | ~m;
        end
        return x;
    endfunction

    // Position of the highest set bit plus one; zero for a zero value.
    function automatic int unsigned bit_count(input logic [63:0] x);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Works out the final poison bit of one operation word under a given
    // configuration. Width is clamped to 1..64 and the shift distance to the
    // width, so an oversized shift examines every active bit of the operand.
    function automatic logic predict_poison(input word_t wd, input cfg_t c);
        int unsigned             ew;
        int unsigned             sh;
        logic [63:0]             m;
        logic [63:0]             lv;
        logic [63:0]             rv;
        logic [63:0]             res;
        logic [63:0]             hi_mask;
        logic [63:0]             top;
        logic [63:0]             prod_low;
        logic [63:0]             hide;
        logic signed [63:0]      sl;
        logic signed [63:0]      sr;
        logic signed [63:0]      sres;
        logic signed [127:0]     wide_l;
        logic signed [127:0]     wide_r;
        logic signed [127:0]     sprod;
        logic signed [127:0]     lim_hi;
        logic signed [127:0]     lim_lo;
        logic                    p;
        logic                    lp;
        logic                    rp;
        logic                    tp;
        logic                    nsw;
        logic                    nuw;
        logic                    exact;
        logic                    anti_logic;

        ew = wd.width;
        if (ew == 0)
        begin
            ew = 1;
        end
        if (ew > 64)
        begin
            ew = 64;
        end
        m = width_mask(ew);
        lv = wd.lhs_value & m;
        rv = wd.rhs_value & m;
        res = wd.result_value & m;
        sh = wd.shift_amount;
        if (sh > ew)
        begin
            sh = ew;
        end
        sl = sign_extend(lv, ew);
        sr = sign_extend(rv, ew);
        sres = sign_extend(res, ew);
        lp = wd.lhs_poison;
        rp = wd.rhs_poison;
        tp = wd.third_poison;
        nsw = wd.flags[FLAG_NSW];
        nuw = wd.flags[FLAG_NUW];
        exact = wd.flags[FLAG_EXACT];
        anti_logic = c.antidote_and_or | c.poison_eq_undef;
        p = wd.result_poison_in;

        case (wd.cmd)
            CMD_ADD:
            begin
                if (nsw && ((sr < 0) ? (sl < sres) : (sres < sl)))
                begin
                    p = 1'b1;
                end
                if (nuw && (res < lv || res < rv))
                begin
                    p = 1'b1;
                end
            end
            CMD_SUB:
            begin
                if (nsw && ((sr > 0) ? (sl < sres) : (sres < sl)))
                begin
                    p = 1'b1;
                end
                if (nuw && lv < rv)
                begin
                    p = 1'b1;
                end
            end
            CMD_MUL:
            begin
                if (c.antidote_and_or && ((lp && rv == 0) || (lv == 0 && rp)))
                begin
                    p = 1'b0;
                end
                else if (lp || rp)
                begin
                    p = 1'b1;
                end
                else
                begin
                    wide_l = sl;
                    wide_r = sr;
                    sprod = wide_l * wide_r;
                    lim_hi = 128'sd1;
                    lim_hi = lim_hi << (ew - 1);
                    lim_lo = -lim_hi;
                    lim_hi = lim_hi - 128'sd1;
                    if (nsw && (sprod > lim_hi || sprod < lim_lo))
                    begin
                        p = 1'b1;
                    end
                    if (nuw && bit_count(lv) + bit_count(rv) > ew)
                    begin
                        p = 1'b1;
                    end
                end
            end
            CMD_DIV_EXACT:
            begin
                prod_low = rv * res;
                if (exact && (prod_low & m) != lv)
                begin
                    p = 1'b1;
                end
            end
            CMD_DIV, CMD_REM, CMD_XOR:
            begin
                p = lp | rp;
            end
            CMD_AND, CMD_OR:
            begin
                hide = (wd.cmd == CMD_AND) ? 64'd0 : m;
                p = lp | rp;
                if (anti_logic && ((lp && !rp && rv == hide) || (!lp && rp && lv == hide)))
                begin
                    p = 1'b0;
                end
            end
            CMD_SHL:
            begin
                if (sh != 0)
                begin
                    hi_mask = m & ~width_mask(ew - sh);
                    top = lv & hi_mask;
                    if (nsw && (res[ew - 1] ? (top != hi_mask) : (top != 0)))
                    begin
                        p = 1'b1;
                    end
                    if (nuw && top != 0)
                    begin
                        p = 1'b1;
                    end
                end
            end
            CMD_LSHR, CMD_ASHR:
            begin
                if (exact && sh != 0 && (lv & width_mask(sh)) != 0)
                begin
                    p = 1'b1;
                end
            end
            CMD_SELECT:
            begin
                if (c.antidote_select)
                begin
                    p = lp | rp | tp;
                end
                else
                begin
                    p = lp | ((lv == 0) ? tp : rp);
                end
            end
            CMD_CONVERT:
            begin
                p = lp;
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // Operand values that sit on the interesting edges of the active width,
    // with random junk above the width half of the time.
    function automatic logic [63:0] pick_operand(input int unsigned ew);
        logic [63:0] m;
        logic [63:0] v;
        m = width_mask(ew);
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = m;
            2: v = 64'd1;
            3: v = m >> 1;
            4: v = 64'd1 << (ew - 1);
            5: v = 64'($urandom_range(0, 15));
            6: v = m - 64'($urandom_range(1, 15));
            default: v = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v = (v & m) | ({$urandom, $urandom} & ~m);
        end
        return v;
    endfunction

    task automatic add_word(input logic [3:0] cmd, input logic [6:0] width,
                            input logic [63:0] lhs, input logic lp,
                            input logic [63:0] rhs, input logic rp, input logic tp,
                            input logic [63:0] res, input logic pin,
                            input logic [5:0] shift, input logic [2:0] flags);
        word_t wd;
        wd.cmd = cmd;
        wd.width = width;
        wd.lhs_value = lhs;
        wd.lhs_poison = lp;
        wd.rhs_value = rhs;
        wd.rhs_poison = rp;
        wd.third_poison = tp;
        wd.result_value = res;
        wd.result_poison_in = pin;
        wd.shift_amount = shift;
        wd.flags = flags;
        pending_words.push_back(wd);
    endtask

    // Register writes happen only while the pipeline is empty, so the
    // predictor's copy of the configuration can be updated right away.
    task automatic write_register(input logic [1:0] idx, input logic val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        case (idx)
            CFG_ANTIDOTE_AND_OR: active_cfg.antidote_and_or = val;
            CFG_POISON_EQ_UNDEF: active_cfg.poison_eq_undef = val;
            CFG_ANTIDOTE_SELECT: active_cfg.antidote_select = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every queued word has been taken and every result has
    // come home, then lets the pipeline go quiet.
    task automatic drain_block();
        while (pending_words.size() != 0 || item_bus.valid)
        begin
            @(posedge clk);
        end
        while (poison_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: a word stays on the bus until it is taken. Between words the
    // sender may idle, at the rate set for the current phase.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
        end
        else if (!item_bus.valid || word_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                item_bus.valid <= 1'b1;
                item_bus.cmd <= pending_words[0].cmd;
                item_bus.width <= pending_words[0].width;
                item_bus.lhs_value <= pending_words[0].lhs_value;
                item_bus.lhs_poison <= pending_words[0].lhs_poison;
                item_bus.rhs_value <= pending_words[0].rhs_value;
                item_bus.rhs_poison <= pending_words[0].rhs_poison;
                item_bus.third_poison <= pending_words[0].third_poison;
                item_bus.result_value <= pending_words[0].result_value;
                item_bus.result_poison_in <= pending_words[0].result_poison_in;
                item_bus.shift_amount <= pending_words[0].shift_amount;
                item_bus.flags <= pending_words[0].flags;
                void'(pending_words.pop_front());
            end
            else
            begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, at the rate set for the current phase.
    always @(negedge clk)
    begin
        result_bus.ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Monitor: every word taken turns into an expected poison bit; every
    // result taken is checked against the oldest one still waiting.
    always @(posedge clk)
    begin
        word_taken <= item_bus.valid && item_bus.ready;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                accepted_word.cmd = item_bus.cmd;
                accepted_word.width = item_bus.width;
                accepted_word.lhs_value = item_bus.lhs_value;
                accepted_word.lhs_poison = item_bus.lhs_poison;
                accepted_word.rhs_value = item_bus.rhs_value;
                accepted_word.rhs_poison = item_bus.rhs_poison;
                accepted_word.third_poison = item_bus.third_poison;
                accepted_word.result_value = item_bus.result_value;
                accepted_word.result_poison_in = item_bus.result_poison_in;
                accepted_word.shift_amount = item_bus.shift_amount;
                accepted_word.flags = item_bus.flags;
                poison_expected.push_back(predict_poison(accepted_word, active_cfg));
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (poison_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected nothing, got poison_out=%0b",
                             $time, result_bus.poison_out);
                end
                else if (result_bus.poison_out !== poison_expected[0])
                begin
                    mismatch_count++;
                    $display("%0t: poison_out mismatch, expected %0b, got %0b",
                             $time, poison_expected[0], result_bus.poison_out);
                    void'(poison_expected.pop_front());
                end
                else
                begin
                    void'(poison_expected.pop_front());
                end
            end
        end
    end

    // Main sequence: reset, a directed pass with the registers at reset
    // values, then random phases that step through register settings and
    // idling patterns. Every phase ends with the sender paused until all
    // results are back, which is also when the registers get rewritten.
    initial
    begin
        int          sender_idle_by_mode[4];
        int          receiver_stall_by_mode[4];
        logic [2:0]  setting_by_phase[RANDOM_PHASES];
        word_t       wd;
        int unsigned ew;
        logic [63:0] lv;
        logic [63:0] rv;

        sender_idle_by_mode = '{0, 67, 0, 25};
        receiver_stall_by_mode = '{0, 0, 67, 25};
        // Bits: antidote_and_or, poison_eq_undef, antidote_select.
        setting_by_phase = '{3'b111, 3'b100, 3'b010, 3'b001,
                             3'b110, 3'b011, 3'b101, 3'b000};

        rst_n = 1'b0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        active_cfg = '0;
        word_taken = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.cmd = '0;
        item_bus.width = '0;
        item_bus.lhs_value = '0;
        item_bus.lhs_poison = 1'b0;
        item_bus.rhs_value = '0;
        item_bus.rhs_poison = 1'b0;
        item_bus.third_poison = 1'b0;
        item_bus.result_value = '0;
        item_bus.result_poison_in = 1'b0;
        item_bus.shift_amount = '0;
        item_bus.flags = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Write every register once at its reset value, and poke the spare
        // index, which must leave the configuration untouched.
        write_register(CFG_ANTIDOTE_AND_OR, 1'b0);
        write_register(CFG_POISON_EQ_UNDEF, 1'b0);
        write_register(CFG_ANTIDOTE_SELECT, 1'b0);
        write_register(CFG_INDEX_SPARE, 1'b1);

        // Directed words: wrap checks at the width extremes, each opcode, the
        // clamped shift, the unnamed opcode and out-of-range widths.
        add_word(CMD_ADD, 7'd64, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'd1, 0, 0,
                 64'h8000_0000_0000_0000, 0, 6'd0, 3'b001);
        add_word(CMD_ADD, 7'd64, '1, 0, 64'd1, 0, 0, 64'd0, 0, 6'd0, 3'b010);
        add_word(CMD_ADD, 7'd1, 64'd1, 0, 64'd0, 0, 0, 64'd1, 0, 6'd0, 3'b011);
        add_word(CMD_SUB, 7'd8, 64'h80, 0, 64'd1, 0, 0, 64'h7F, 0, 6'd0, 3'b011);
        add_word(CMD_SUB, 7'd64, 64'd0, 0, 64'd1, 0, 0, '1, 0, 6'd0, 3'b010);
        add_word(CMD_MUL, 7'd64, 64'h8000_0000_0000_0000, 0, '1, 0, 0,
                 64'h8000_0000_0000_0000, 0, 6'd0, 3'b001);
        add_word(CMD_MUL, 7'd8, 64'h10, 0, 64'h10, 0, 0, 64'd0, 0, 6'd0, 3'b010);
        add_word(CMD_MUL, 7'd32, 64'd5, 1, 64'd0, 0, 0, 64'd0, 0, 6'd0, 3'b000);
        add_word(CMD_DIV_EXACT, 7'd16, 64'd12, 0, 64'd4, 0, 0, 64'd3, 0, 6'd0, 3'b100);
        add_word(CMD_DIV_EXACT, 7'd16, 64'd13, 0, 64'd4, 0, 0, 64'd3, 0, 6'd0, 3'b100);
        add_word(CMD_DIV, 7'd32, 64'd9, 1, 64'd3, 0, 0, 64'd3, 0, 6'd0, 3'b000);
        add_word(CMD_REM, 7'd32, 64'd9, 0, 64'd4, 1, 0, 64'd1, 0, 6'd0, 3'b000);
        add_word(CMD_XOR, 7'd32, 64'd9, 0, 64'd4, 0, 0, 64'd13, 1, 6'd0, 3'b111);
        add_word(CMD_AND, 7'd16, 64'hFFFF, 1, 64'd0, 0, 0, 64'd0, 0, 6'd0, 3'b000);
        add_word(CMD_OR, 7'd16, 64'hFFFF, 0, 64'h1234, 1, 0, 64'hFFFF, 0, 6'd0, 3'b000);
        add_word(CMD_SHL, 7'd8, 64'hFF, 0, 64'd0, 0, 0, 64'hFF, 0, 6'd0, 3'b011);
        add_word(CMD_SHL, 7'd8, 64'h01, 0, 64'd0, 0, 0, 64'd0, 0, 6'd63, 3'b010);
        add_word(CMD_SHL, 7'd127, '1, 0, 64'd0, 0, 0, 64'h8000_0000_0000_0000, 0,
                 6'd63, 3'b001);
        add_word(CMD_LSHR, 7'd32, 64'h10, 0, 64'd0, 0, 0, 64'h1, 0, 6'd4, 3'b100);
        add_word(CMD_ASHR, 7'd8, 64'h80, 0, 64'd0, 0, 0, 64'hFF, 0, 6'd40, 3'b100);
        add_word(CMD_SELECT, 7'd1, 64'd0, 0, 64'd1, 0, 1, 64'd0, 0, 6'd0, 3'b000);
        add_word(CMD_SELECT, 7'd64, 64'd1, 0, 64'd1, 1, 0, 64'd1, 0, 6'd0, 3'b000);
        add_word(CMD_CONVERT, 7'd16, 64'd7, 1, 64'd0, 0, 0, 64'd7, 0, 6'd0, 3'b000);
        add_word(CMD_PASS, 7'd16, 64'd7, 0, 64'd0, 0, 0, 64'd7, 1, 6'd0, 3'b000);
        add_word(CMD_RESERVED, 7'd0, '1, 1, '1, 1, 1, '1, 1, 6'd63, 3'b111);
        drain_block();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_register(CFG_ANTIDOTE_AND_OR, setting_by_phase[phase][2]);
            write_register(CFG_POISON_EQ_UNDEF, setting_by_phase[phase][1]);
            write_register(CFG_ANTIDOTE_SELECT, setting_by_phase[phase][0]);
            sender_idle_pct = sender_idle_by_mode[phase % 4];
            receiver_stall_pct = receiver_stall_by_mode[phase % 4];

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Mostly legal opcodes; the unnamed one shows up now and then.
                wd.cmd = ($urandom_range(0, 49) == 0) ? CMD_RESERVED
                                                       : 4'($urandom_range(0, 14));
                // Widths lean on the ends; a few fall outside 1..64.
                case ($urandom_range(0, 9))
                    0: wd.width = 7'd64;
                    1: wd.width = 7'd1;
                    2: wd.width = 7'($urandom_range(0, 127));
                    default: wd.width = 7'($urandom_range(1, 64));
                endcase
                ew = (wd.width == 0) ? 1 : ((wd.width > 64) ? 64 : wd.width);
                wd.lhs_value = pick_operand(ew);
                wd.rhs_value = pick_operand(ew);
                wd.shift_amount = ($urandom_range(0, 1) == 1)
                                  ? 6'($urandom_range(0, 63))
                                  : 6'($urandom_range(0, (ew < 63) ? ew : 63));
                wd.lhs_poison = ($urandom_range(0, 3) == 0);
                wd.rhs_poison = ($urandom_range(0, 3) == 0);
                wd.third_poison = ($urandom_range(0, 3) == 0);
                wd.result_poison_in = ($urandom_range(0, 3) == 0);
                wd.flags = 3'($urandom_range(0, 7));
                wd.result_value = {$urandom, $urandom};
                // For add, sub, mul, shl, lshr and exact divide, three words in four carry
                // the true wrapped result, so the wrap and exactness checks see real operations.
                if ($urandom_range(0, 3) != 0)
                begin
                    lv = wd.lhs_value;
                    rv = wd.rhs_value;
                    case (wd.cmd)
                        CMD_ADD: wd.result_value = lv + rv;
                        CMD_SUB: wd.result_value = lv - rv;
                        CMD_MUL: wd.result_value = lv * rv;
                        CMD_SHL: wd.result_value = lv << wd.shift_amount;
                        CMD_LSHR: wd.result_value = (lv & width_mask(ew)) >> wd.shift_amount;
                        CMD_DIV_EXACT:
                        begin
                            wd.result_value = pick_operand(ew);
                            wd.lhs_value = rv * wd.result_value;
                        end
                        default: ;
                    endcase
                end
                pending_words.push_back(wd);
            end
            drain_block();
        end

        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
